@@ sv/bmm_pkg.sv @@
`default_nettype none

package bmm_pkg;

   typedef enum logic [2:0] {
      OP_MEM_READ    = 3'd0,
      OP_MEM_WRITE   = 3'd1,
      OP_BLOCK_WRITE = 3'd2,
      OP_BLOCK_READ  = 3'd3,
      OP_MODE_SET    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACK       = 3'd0,
      KIND_UNMAPPED  = 3'd1,
      KIND_RAM_READ  = 3'd2,
      KIND_RAM_WRITE = 3'd3,
      KIND_ROM_READ  = 3'd4,
      KIND_READBACK  = 3'd5
   } access_kind_type;

   localparam logic [15:0] RED_BASE   = 16'h6000;
   localparam logic [15:0] GREEN_BASE = 16'hA000;
   localparam logic [15:0] BLUE_BASE  = 16'hE000;
   localparam logic [7:0]  CODE_RESET = 8'hFF;
   localparam logic [3:0]  MODE_RESET = 4'h0;
   localparam int unsigned COPY_BIT   = 3;

   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;

   // One decoded result, or in copy mode the seed for three plane writes.
   typedef struct packed {
      access_kind_type kind;
      logic [15:0]     phys_address;
      logic [7:0]      write_byte;
      logic [7:0]      read_byte;
      logic            copy;
      logic [2:0]      plane_en;
      logic [12:0]     half_off;
   } rsp_entry_type;

   typedef struct packed {
      logic       code_en;
      logic       mode_en;
      logic [3:0] index;
      logic [7:0] data;
   } map_write_type;

   function automatic logic [15:0] plane_base(input logic [1:0] plane);
      logic [15:0] base;
      case (plane)
         PLANE_RED:   base = RED_BASE;
         PLANE_GREEN: base = GREEN_BASE;
         default:     base = BLUE_BASE;
      endcase
      return base;
   endfunction

   function automatic logic [1:0] plane_of(input logic [7:0] code);
      logic [1:0] plane;
      case (code)
         8'hE6, 8'hE7: plane = PLANE_RED;
         8'hEA, 8'hEB: plane = PLANE_GREEN;
         default:      plane = PLANE_BLUE;
      endcase
      return plane;
   endfunction

endpackage

`default_nettype wire

@@ sv/bmm_if.sv @@
`default_nettype none

interface bmm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output opcode, output address, output data, input ready);
   modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

interface bmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  access_kind;
   logic [15:0] phys_address;
   logic [7:0]  write_byte;
   logic [7:0]  read_byte;
   logic        last;

   modport source (output valid, output access_kind, output phys_address,
                   output write_byte, output read_byte, output last, input ready);
   modport sink   (input valid, input access_kind, input phys_address,
                   input write_byte, input read_byte, input last, output ready);
endinterface

`default_nettype wire

@@ sv/bmm_map_regs.sv @@
`default_nettype none

module bmm_map_regs (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bmm_pkg::map_write_type wr,
   input  wire logic [3:0]             rd_index,
   output logic [7:0]                  rd_code,
   output logic [3:0]                  mode
);

   logic [7:0] codes_ff [16];
   logic [3:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            codes_ff[i] <= bmm_pkg::CODE_RESET;
         end
         mode_ff <= bmm_pkg::MODE_RESET;
      end else begin
         if (wr.code_en) begin
            codes_ff[wr.index] <= wr.data;
         end
         if (wr.mode_en) begin
            mode_ff <= wr.data[3:0];
         end
      end
   end

   assign rd_code = codes_ff[rd_index];
   assign mode    = mode_ff;

endmodule

`default_nettype wire

@@ sv/bmm_decode.sv @@
`default_nettype none

module bmm_decode (
   input  wire logic [2:0]            opcode,
   input  wire logic [15:0]           address,
   input  wire logic [7:0]            data,
   input  wire logic [7:0]            code,
   input  wire logic [3:0]            mode,
   output bmm_pkg::rsp_entry_type     entry
);

   logic        is_ram;
   logic        is_rom;
   logic        is_plane;
   logic [11:0] off;

   assign off      = address[11:0];
   assign is_ram   = code inside {[8'hE0:8'hEF]};
   assign is_rom   = code inside {[8'hFC:8'hFF]};
   assign is_plane = code inside {8'hE6, 8'hE7, 8'hEA, 8'hEB, 8'hEE, 8'hEF};

   always_comb begin
      entry              = '0;
      entry.kind         = bmm_pkg::KIND_ACK;
      case (bmm_pkg::op_type'(opcode))
         bmm_pkg::OP_MEM_READ: begin
            if (is_ram) begin
               entry.kind         = bmm_pkg::KIND_RAM_READ;
               entry.phys_address = {code[3:0], off};
            end else if (is_rom) begin
               entry.kind         = bmm_pkg::KIND_ROM_READ;
               entry.phys_address = {2'b00, code[1:0], off};
            end else begin
               entry.kind = bmm_pkg::KIND_UNMAPPED;
            end
         end
         bmm_pkg::OP_MEM_WRITE: begin
            if (!is_ram) begin
               entry.kind = bmm_pkg::KIND_UNMAPPED;
            end else begin
               entry.kind       = bmm_pkg::KIND_RAM_WRITE;
               entry.write_byte = data;
               entry.half_off   = {code[0], off};
               if (!is_plane) begin
                  entry.phys_address = {code[3:0], off};
               end else if (mode[bmm_pkg::COPY_BIT]) begin
                  // The three plane addresses are formed beat by beat at the output.
                  entry.copy     = 1'b1;
                  entry.plane_en = mode[2:0];
               end else begin
                  entry.phys_address = bmm_pkg::plane_base(bmm_pkg::plane_of(code))
                                       | {3'b000, code[0], off};
               end
            end
         end
         bmm_pkg::OP_BLOCK_READ: begin
            entry.kind      = bmm_pkg::KIND_READBACK;
            entry.read_byte = code;
         end
         default: begin
            entry.kind = bmm_pkg::KIND_ACK;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/bmm_beat_seq.sv @@
`default_nettype none

module bmm_beat_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire bmm_pkg::rsp_entry_type entry_in,
   output logic                        free,
   bmm_rsp_if.source                   rsp
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [1:0]             beat_ff;
   logic [1:0]             beat_in;
   bmm_pkg::rsp_entry_type entry_ff;
   logic                   last_beat;

   assign last_beat = !entry_ff.copy || (beat_ff == bmm_pkg::PLANE_BLUE);
   assign free      = !valid_ff || (rsp.ready && last_beat);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = bmm_pkg::PLANE_RED;
      end else if (valid_ff && rsp.ready) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= bmm_pkg::PLANE_RED;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   // In copy mode each transfer goes to the next plane: red, green, then blue.
   always_comb begin
      rsp.valid       = valid_ff;
      rsp.access_kind = entry_ff.kind;
      rsp.read_byte   = entry_ff.read_byte;
      rsp.last        = last_beat;
      if (entry_ff.copy) begin
         rsp.phys_address = bmm_pkg::plane_base(beat_ff) | {3'b000, entry_ff.half_off};
         rsp.write_byte   = entry_ff.plane_en[beat_ff] ? entry_ff.write_byte : 8'h00;
      end else begin
         rsp.phys_address = entry_ff.phys_address;
         rsp.write_byte   = entry_ff.write_byte;
      end
   end

endmodule

`default_nettype wire

@@ sv/banked_memory_mapper_with_plane_writes.sv @@
// A request passes through the input register, then the result register, before its result
// can be transferred; either register holds its request while the output stalls.
// Throughput: one request per cycle while results are accepted; a copy-mode plane write holds
// the result register for three transfers, which stalls the requests behind it.
// Reset (synchronous): empties both registers, sets every window code to 0xFF and the
// write mode to zero.
`default_nettype none

module banked_memory_mapper_with_plane_writes (
   input  wire logic clock,
   input  wire logic reset,
   bmm_req_if.sink   req_bus,
   bmm_rsp_if.source rsp_bus
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [2:0]  in_opcode_ff;
   logic [15:0] in_address_ff;
   logic [7:0]  in_data_ff;

   logic                   req_take;
   logic                   seq_free;
   logic                   advance;
   logic [3:0]             rd_index;
   logic [7:0]             rd_code;
   logic [3:0]             mode;
   bmm_pkg::map_write_type map_wr;
   bmm_pkg::rsp_entry_type entry;

   assign advance       = in_valid_ff && seq_free;
   assign req_bus.ready = !in_valid_ff || seq_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_opcode_ff  <= req_bus.opcode;
         in_address_ff <= req_bus.address;
         in_data_ff    <= req_bus.data;
      end
   end

   // Register reads use the low index bits; memory accesses use the window number.
   assign rd_index = (in_opcode_ff == bmm_pkg::OP_BLOCK_READ) ? in_address_ff[3:0]
                                                              : in_address_ff[15:12];

   // State changes when the request leaves the input register, so the next one sees them.
   always_comb begin
      map_wr.code_en = advance && (in_opcode_ff == bmm_pkg::OP_BLOCK_WRITE);
      map_wr.mode_en = advance && (in_opcode_ff == bmm_pkg::OP_MODE_SET);
      map_wr.index   = in_address_ff[3:0];
      map_wr.data    = in_data_ff;
   end

   bmm_map_regs u_map_regs (
      .clock    (clock),
      .reset    (reset),
      .wr       (map_wr),
      .rd_index (rd_index),
      .rd_code  (rd_code),
      .mode     (mode)
   );

   bmm_decode u_decode (
      .opcode  (in_opcode_ff),
      .address (in_address_ff),
      .data    (in_data_ff),
      .code    (rd_code),
      .mode    (mode),
      .entry   (entry)
   );

   bmm_beat_seq u_beat_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .entry_in (entry),
      .free     (seq_free),
      .rsp      (rsp_bus)
   );

`ifndef SYNTHESIS
   ap_nonlast_followed: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid)
      else $error("A non-final transfer was not followed by another result.");

   ap_nonlast_is_write: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last |-> rsp_bus.access_kind == bmm_pkg::KIND_RAM_WRITE)
      else $error("Only plane copy writes may give several results.");

   ap_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("Request refused while the input register was empty.");

   ap_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !seq_free |=> in_valid_ff && $stable(in_opcode_ff)
                                   && $stable(in_address_ff))
      else $error("A waiting request was lost from the input register.");
`endif

endmodule

`default_nettype wire
